// ----- src/ihas_pkg.sv -----
`default_nettype none

package ihas_pkg;

  // Build-time defaults and fixed sizes.
  localparam int unsigned BACKLOG_DEPTH_DEF = 16;
  localparam int unsigned WALK_MAX = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register file of the configuration port.
  localparam int unsigned APB_AW = 3;
  localparam logic REG_BACKLOG_DEPTH = 1'b0;
  localparam logic [4:0] DEPTH_RESET = 5'd16;

  // Header field constants.
  localparam logic [3:0] HL_MIN = 4'd5;
  localparam logic [7:0] TOS_LIMIT = 8'd32;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [15:0] PRIVATE_NET = 16'hC0A8;
  localparam logic [7:0] MARTIAN_TOP = 8'd223;
  localparam logic [7:0] LOOPBACK_NET = 8'd127;

  // Anomaly flag bit positions.
  localparam int unsigned FLAG_HL = 0;
  localparam int unsigned FLAG_TOS = 1;
  localparam int unsigned FLAG_SHORT = 2;
  localparam int unsigned FLAG_FRAG = 3;
  localparam int unsigned FLAG_RSVD = 4;
  localparam int unsigned FLAG_PROTO = 5;

  // Prefix lengths.
  localparam logic [5:0] PLEN_NONE = 6'd0;
  localparam logic [5:0] PLEN_8 = 6'd8;
  localparam logic [5:0] PLEN_16 = 6'd16;
  localparam logic [5:0] PLEN_24 = 6'd24;
  localparam logic [5:0] PLEN_32 = 6'd32;

  // Strength of an address rule that fired before the equality chain.
  localparam logic [1:0] LEVEL_NONE = 2'd0;
  localparam logic [1:0] LEVEL_SPECIAL = 2'd1;
  localparam logic [1:0] LEVEL_PRIVATE = 2'd2;

  // A classified header as it travels from the front to the back.
  typedef struct packed {
    logic [3:0]  header_words;
    logic [7:0]  service_type;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [5:0]  fixed_flags;
    logic        src_ones;
    logic [5:0]  src_len;
    logic [1:0]  src_level;
    logic        dst_ones;
    logic [5:0]  dst_len;
    logic [1:0]  dst_level;
  } ihas_item_t;

  // One stored header in the backlog ring.
  typedef struct packed {
    logic [3:0]  hl;
    logic [7:0]  tos;
    logic [31:0] src;
    logic [31:0] dst;
  } ihas_entry_t;

  // One signature word.
  typedef struct packed {
    logic [3:0]  count;
    logic [5:0]  flags;
    logic [3:0]  slot;
    logic [5:0]  src_len;
    logic [31:0] src_prefix;
    logic [5:0]  dst_len;
    logic [31:0] dst_prefix;
  } ihas_sig_t;

  // Control from the register file to the back.
  typedef struct packed {
    logic       clear;
    logic [4:0] limit;
  } ihas_ctrl_t;

  // Ring size actually used for a given backlog parameter.
  function automatic int unsigned ihas_ring_size(input int unsigned depth);
    return (depth < WALK_MAX) ? depth : WALK_MAX;
  endfunction

  function automatic logic ihas_is_martian(input logic [31:0] a);
    return (a[31:24] > MARTIAN_TOP) || (a[31:24] == LOOPBACK_NET) || (a[31:24] == 8'd0);
  endfunction

  function automatic logic [31:0] ihas_prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    unique case (len)
      PLEN_32: m = 32'hFFFF_FFFF;
      PLEN_24: m = 32'hFFFF_FF00;
      PLEN_16: m = 32'hFFFF_0000;
      PLEN_8:  m = 32'hFF00_0000;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

  // Equality chain against a stored address; earlier rules block short steps.
  function automatic logic [5:0] ihas_prefix_len(input logic [31:0] a,
                                                 input logic [31:0] old,
                                                 input logic ones,
                                                 input logic [5:0] rule_len,
                                                 input logic [1:0] level);
    logic [5:0] len;
    len = rule_len;
    if (ones) begin
      len = PLEN_32;
    end else if (a == old) begin
      len = PLEN_32;
    end else if ((a[31:8] == old[31:8]) && (level <= LEVEL_PRIVATE)) begin
      len = PLEN_24;
    end else if ((a[31:16] == old[31:16]) && (level <= LEVEL_SPECIAL)) begin
      len = PLEN_16;
    end else if (a[31:24] == old[31:24]) begin
      len = PLEN_8;
    end
    return len;
  endfunction

  function automatic logic [3:0] ihas_popcount6(input logic [5:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 6; b++) begin
      n = n + {3'd0, v[b]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- src/ihas_front.sv -----
`default_nettype none

module ihas_front
  import ihas_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  header_words,
  input  wire logic [7:0]  service_type,
  input  wire logic [15:0] total_length,
  input  wire logic [15:0] fragment_word,
  input  wire logic [7:0]  protocol,
  input  wire logic [31:0] source_address,
  input  wire logic [31:0] dest_address,
  output logic             item_valid,
  input  wire logic        item_stall,
  output ihas_item_t       item
);

  ihas_item_t cls;
  logic [16:0] frag_end;
  logic        take;

  // Classify the header: flags and address rules that need no stored header.
  always_comb begin
    frag_end = {1'b0, fragment_word[12:0], 3'b000} + {1'b0, total_length};
    cls = '0;
    cls.header_words = header_words;
    cls.service_type = service_type;
    cls.source_address = source_address;
    cls.dest_address = dest_address;
    cls.fixed_flags[FLAG_HL] = header_words < HL_MIN;
    cls.fixed_flags[FLAG_SHORT] = total_length < {10'd0, header_words, 2'b00};
    cls.fixed_flags[FLAG_FRAG] = frag_end[16];
    cls.fixed_flags[FLAG_RSVD] = fragment_word[15];
    cls.fixed_flags[FLAG_PROTO] = (protocol != PROTO_TCP) && (protocol != PROTO_UDP) &&
                                  (protocol != PROTO_ICMP) && (protocol != PROTO_IGMP);

    // Source rules: martian, then the private /16 overrides it.
    cls.src_ones = &source_address;
    cls.src_len = PLEN_NONE;
    cls.src_level = LEVEL_NONE;
    if (ihas_is_martian(source_address)) begin
      cls.src_len = PLEN_8;
      cls.src_level = LEVEL_SPECIAL;
    end
    if (source_address[31:16] == PRIVATE_NET) begin
      cls.src_len = PLEN_16;
      cls.src_level = LEVEL_PRIVATE;
    end

    // Destination rules: network address, then martian overrides it.
    cls.dst_ones = &dest_address;
    cls.dst_len = PLEN_NONE;
    cls.dst_level = LEVEL_NONE;
    if (dest_address[7:0] == 8'd0) begin
      cls.dst_len = PLEN_32;
      cls.dst_level = LEVEL_SPECIAL;
    end
    if (ihas_is_martian(dest_address)) begin
      cls.dst_len = PLEN_8;
      cls.dst_level = LEVEL_SPECIAL;
    end
  end

  assign take = !item_valid || !item_stall;
  assign in_stall = !take;

  // Output register of the front.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= in_valid;
      item <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- src/ihas_queue.sv -----
`default_nettype none

module ihas_queue
  import ihas_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push_valid,
  output logic            push_stall,
  input  wire ihas_item_t push_item,
  output logic            head_valid,
  input  wire logic       pop,
  output ihas_item_t      head_item
);

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  ihas_item_t slots [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_stall = (fill == FW'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_item = slots[rd_ptr];
  assign do_push = push_valid && !push_stall;
  assign do_pop = pop && head_valid;

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Storage of queued words.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- src/ihas_back.sv -----
`default_nettype none

module ihas_back
  import ihas_pkg::*;
#(
  parameter int unsigned BACKLOG_DEPTH = BACKLOG_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ihas_ctrl_t ctrl,
  input  wire logic       head_valid,
  input  wire ihas_item_t head_item,
  output logic            head_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output ihas_sig_t       out_sig,
  output logic            out_last
);

  localparam int unsigned RING_SIZE = ihas_ring_size(BACKLOG_DEPTH);
  localparam int unsigned RING_AW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;

  ihas_entry_t ring [RING_SIZE];
  ihas_entry_t rd_data;
  ihas_entry_t new_entry;

  ihas_item_t cur;
  logic       busy;
  logic [4:0] idx;
  logic [3:0] slot;
  logic       rd_valid;
  logic [3:0] rd_idx;
  logic       pend_valid;
  ihas_sig_t  pend;
  logic [4:0] kept_count;
  logic [3:0] oldest_slot;

  logic       out_free;
  logic       go;
  logic       walk_more;
  logic       finish;
  logic       start;
  logic       rd_en;
  logic [3:0] slot_next;
  logic [3:0] oldest_next;
  logic [4:0] wr_sum;
  logic [4:0] wr_slot;
  logic [5:0] flags;
  logic [5:0] slen;
  logic [5:0] dlen;
  logic [3:0] cnt;
  logic       emit;
  ihas_sig_t  sig;

  // Walk control: one ring read per cycle unless the output stalls; the pending word waits for the next one.
  assign out_free = !out_valid || !out_stall;
  assign go = !pend_valid || out_free;
  assign walk_more = busy && (idx < kept_count);
  assign finish = busy && go && !walk_more && !rd_valid;
  assign start = !busy && head_valid;
  assign head_pop = start;
  assign rd_en = busy && go && walk_more;

  assign slot_next = (({1'b0, slot} + 5'd1) == ctrl.limit) ? 4'd0 : slot + 4'd1;
  assign oldest_next = (({1'b0, oldest_slot} + 5'd1) == ctrl.limit) ? 4'd0
                                                                     : oldest_slot + 4'd1;
  assign wr_sum = {1'b0, oldest_slot} + kept_count;
  assign wr_slot = (kept_count < ctrl.limit) ?
                   ((wr_sum >= ctrl.limit) ? wr_sum - ctrl.limit : wr_sum) :
                   {1'b0, oldest_slot};

  always_comb begin
    new_entry.hl = cur.header_words;
    new_entry.tos = cur.service_type;
    new_entry.src = cur.source_address;
    new_entry.dst = cur.dest_address;
  end

  // Score the new header against the stored one held in the registered read data.
  always_comb begin
    flags = cur.fixed_flags;
    if ((rd_data.hl == cur.header_words) && (cur.header_words != HL_MIN)) begin
      flags[FLAG_HL] = 1'b1;
    end
    if ((rd_data.tos == cur.service_type) && (cur.service_type > TOS_LIMIT)) begin
      flags[FLAG_TOS] = 1'b1;
    end
    slen = ihas_prefix_len(cur.source_address, rd_data.src, cur.src_ones,
                           cur.src_len, cur.src_level);
    dlen = ihas_prefix_len(cur.dest_address, rd_data.dst, cur.dst_ones,
                           cur.dst_len, cur.dst_level);
    cnt = ihas_popcount6(flags) + {3'd0, slen != PLEN_NONE} + {3'd0, dlen != PLEN_NONE};
    emit = rd_valid && (cnt != 4'd0);
    sig.count = cnt;
    sig.flags = flags;
    sig.slot = rd_idx;
    sig.src_len = slen;
    sig.src_prefix = cur.source_address & ihas_prefix_mask(slen);
    sig.dst_len = dlen;
    sig.dst_prefix = cur.dest_address & ihas_prefix_mask(dlen);
  end

  // Sequencer, pending word, output register and ring bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rd_valid <= 1'b0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
      kept_count <= 5'd0;
      oldest_slot <= 4'd0;
    end else begin
      if (out_free) begin
        out_valid <= 1'b0;
      end
      if (ctrl.clear) begin
        kept_count <= 5'd0;
        oldest_slot <= 4'd0;
      end
      if (start) begin
        busy <= 1'b1;
        cur <= head_item;
        idx <= 5'd0;
        slot <= oldest_slot;
      end
      if (busy && go) begin
        rd_valid <= walk_more;
        if (walk_more) begin
          idx <= idx + 5'd1;
          slot <= slot_next;
          rd_idx <= idx[3:0];
        end
        if (emit) begin
          pend <= sig;
          pend_valid <= 1'b1;
          if (pend_valid) begin
            out_valid <= 1'b1;
            out_sig <= pend;
            out_last <= 1'b0;
          end
        end
      end
      if (finish) begin
        busy <= 1'b0;
        pend_valid <= 1'b0;
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_sig <= pend;
          out_last <= 1'b1;
        end
        if (kept_count < ctrl.limit) begin
          kept_count <= kept_count + 5'd1;
        end else begin
          oldest_slot <= oldest_next;
        end
      end
    end
  end

  // Backlog ring: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (finish) begin
      ring[wr_slot[RING_AW-1:0]] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ring[slot[RING_AW-1:0]];
    end
  end

  // Checks on the walk.
  a_count_in_limit: assert property (@(posedge clk) disable iff (rst)
    kept_count <= ctrl.limit)
    else $error("backlog fill exceeds the ring limit");

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> busy)
    else $error("pending signature outside a walk");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> busy)
    else $error("ring read data outside a walk");

  a_last_out: assert property (@(posedge clk) disable iff (rst)
    (finish && pend_valid) |=> (out_valid && out_last))
    else $error("final signature of a header not delivered");

endmodule

`default_nettype wire

// ----- src/ip_header_anomaly_signature.sv -----
`default_nettype none

// IPv4 header anomaly signature engine. Each header word accepted on the input
// is scored against the headers held in a backlog ring, oldest first, and one
// signature word leaves for every stored header that scores above zero; last
// marks the final signature of a header, and a header with no scoring pair
// leaves none. The header then enters the ring. A front stage classifies the
// header and hands it through a two-word queue to the back, which reads one
// ring entry per cycle while the output is not stalled. The ring holds at most
// the clamped ring limit of headers, at most 16. The front keeps accepting
// while the back walks until the queue is full. Writing backlog_depth
// (register 0; the ring limit it sets is clamped to 1..16 and to BACKLOG_DEPTH,
// while the register reads back as written) empties the ring; write it only
// when idle.

module ip_header_anomaly_signature
  import ihas_pkg::*;
#(
  parameter int unsigned BACKLOG_DEPTH = BACKLOG_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [3:0]        header_words,
  input  wire logic [7:0]        service_type,
  input  wire logic [15:0]       total_length,
  input  wire logic [15:0]       fragment_word,
  input  wire logic [7:0]        protocol,
  input  wire logic [31:0]       source_address,
  input  wire logic [31:0]       dest_address,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [3:0]             anomaly_count,
  output logic [5:0]             anomaly_flags,
  output logic [3:0]             matched_slot,
  output logic [5:0]             source_prefix_len,
  output logic [31:0]            source_prefix,
  output logic [5:0]             dest_prefix_len,
  output logic [31:0]            dest_prefix,
  output logic                   last
);

  localparam int unsigned RING_SIZE = ihas_ring_size(BACKLOG_DEPTH);
  localparam logic [4:0] RING_LIMIT = 5'(RING_SIZE);

  logic [4:0] backlog_depth;
  logic [4:0] limit;
  logic [4:0] limit_next;
  logic       wr_hit;
  ihas_ctrl_t ctrl;

  logic       item_valid;
  logic       item_stall;
  ihas_item_t item;
  logic       head_valid;
  logic       head_pop;
  ihas_item_t head_item;
  ihas_sig_t  sig;

  // Register file: backlog depth plus the clamped ring limit it implies.
  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == REG_BACKLOG_DEPTH);
  assign limit_next = (pwdata[4:0] == 5'd0) ? 5'd1 :
                      (pwdata[4:0] > RING_LIMIT) ? RING_LIMIT : pwdata[4:0];
  assign prdata = (paddr[2] == REG_BACKLOG_DEPTH) ? {27'd0, backlog_depth} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlog_depth <= DEPTH_RESET;
      limit <= RING_LIMIT;
    end else if (wr_hit) begin
      backlog_depth <= pwdata[4:0];
      limit <= limit_next;
    end
  end

  assign ctrl.clear = wr_hit;
  assign ctrl.limit = limit;

  ihas_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .header_words   (header_words),
    .service_type   (service_type),
    .total_length   (total_length),
    .fragment_word  (fragment_word),
    .protocol       (protocol),
    .source_address (source_address),
    .dest_address   (dest_address),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item)
  );

  ihas_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (item_valid),
    .push_stall (item_stall),
    .push_item  (item),
    .head_valid (head_valid),
    .pop        (head_pop),
    .head_item  (head_item)
  );

  ihas_back #(
    .BACKLOG_DEPTH (BACKLOG_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sig    (sig),
    .out_last   (last)
  );

  // Signature word onto its field ports.
  assign anomaly_count = sig.count;
  assign anomaly_flags = sig.flags;
  assign matched_slot = sig.slot;
  assign source_prefix_len = sig.src_len;
  assign source_prefix = sig.src_prefix;
  assign dest_prefix_len = sig.dst_len;
  assign dest_prefix = sig.dst_prefix;

endmodule

`default_nettype wire
